[hdl/rmcd_pkg.sv]
// ----------------------------------------------------------------------------
// rmcd_pkg
// Shared widths, the square-root pipeline record and its one-bit step.
// ----------------------------------------------------------------------------
package rmcd_pkg;

    localparam int CHAN_W     = 8;
    localparam int SUM_W      = 20;
    localparam int RAD_W      = SUM_W + 8;     // sum scaled by 256 for Q4 output
    localparam int SQRT_STEPS = RAD_W / 2;     // one root bit per stage
    localparam int DIST_W     = SQRT_STEPS;
    localparam int REM_W      = DIST_W + 3;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [REM_W-1:0]  rem;
        logic [DIST_W-1:0] root;
    } rmcd_sqrt_t;

    // Take in the next two radicand bits and decide one root bit.
    function automatic rmcd_sqrt_t sqrt_step(input rmcd_sqrt_t cur, input logic [1:0] pair);
        rmcd_sqrt_t        nxt;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        nxt    = cur;
        rem_sh = {cur.rem[REM_W-3:0], pair};
        trial  = {1'b0, cur.root, 2'b01};
        if (rem_sh >= trial)
        begin
            nxt.rem  = rem_sh - trial;
            nxt.root = {cur.root[DIST_W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = rem_sh;
            nxt.root = {cur.root[DIST_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

[hdl/rmcd_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// rmcd_sqrt_pipe
// Pipelined integer square root of sum*256, one root bit per stage.
// ----------------------------------------------------------------------------
module rmcd_sqrt_pipe
    import rmcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [SUM_W-1:0]  in_sum,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SUM_W-1:0]  out_sum,
    output logic [DIST_W-1:0] out_root
);

    logic       valid_reg [SQRT_STEPS];
    rmcd_sqrt_t data_reg  [SQRT_STEPS];
    logic       stage_ready [SQRT_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++)
        begin : g_stage
            localparam int PairLsb = 2 * (SQRT_STEPS - 1 - k);
            logic             prev_valid;
            rmcd_sqrt_t       prev_data;
            logic [RAD_W-1:0] rad;
            rmcd_sqrt_t       data_next;

            if (k == 0)
            begin : g_head
                assign prev_valid = in_valid;
                assign prev_data  = '{sum: in_sum, rem: '0, root: '0};
            end
            else
            begin : g_body
                assign prev_valid = valid_reg[k-1];
                assign prev_data  = data_reg[k-1];
            end

            if (k == SQRT_STEPS - 1)
            begin : g_tail
                assign stage_ready[k] = !valid_reg[k] || out_ready;
            end
            else
            begin : g_mid
                assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
            end

            assign rad       = {prev_data.sum, 8'h00};
            assign data_next = sqrt_step(prev_data, rad[PairLsb +: 2]);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (stage_ready[k])
                begin
                    valid_reg[k] <= prev_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[k] && prev_valid)
                begin
                    data_reg[k] <= data_next;
                end
            end
        end
    endgenerate

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[SQRT_STEPS-1];
    assign out_sum   = data_reg[SQRT_STEPS-1].sum;
    assign out_root  = data_reg[SQRT_STEPS-1].root;

endmodule

[hdl/redmean_color_distance_unit.sv]
// ----------------------------------------------------------------------------
// redmean_color_distance_unit
// Redmean weighted color distance of two RGB colors, with Q4 square root.
// ----------------------------------------------------------------------------
//
//  channel   dir  bits  contents
//  s_axis    in   48    color pair request
//  m_axis    out  40    weighted sum and Q4 distance
//
//  One request enters per cycle while s_tready is high; it passes 4 arithmetic
//  stages, then 14 square-root stages, one root bit each; the root width sets their count.
//  Reset clears only the stage valid bits; payload registers hold garbage.
//  Each stage advances when it is empty or the next stage takes its data,
//  so bubbles collapse under back-pressure and nothing is dropped or repeated.
//  With the whole pipe full and m_tready low, s_tready drops.
//
module redmean_color_distance_unit
    import rmcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_red, first_green, first_blue, second_red, second_green, second_blue
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // weighted_sum[19:0], distance_q4[33:20], zero pad[39:34]
    output logic [39:0] m_tdata
);

    // Unpack the request fields.
    logic [CHAN_W-1:0] r1, g1, b1, r2, g2, b2;
    assign r1 = s_tdata[7:0];
    assign g1 = s_tdata[15:8];
    assign b1 = s_tdata[23:16];
    assign r2 = s_tdata[31:24];
    assign g2 = s_tdata[39:32];
    assign b2 = s_tdata[47:40];

    // Stage handshake: a stage loads when empty or when its output moves on.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, sq_ready;

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s4_ready = !s4_valid_reg || sq_ready;
    assign s_tready = s1_ready;

    // Stage 1: red mean and absolute channel differences.
    logic [CHAN_W-1:0] rmean_reg, dr_reg, dg_reg, db_reg;
    logic [CHAN_W-1:0] rmean_next, dr_next, dg_next, db_next;
    logic [CHAN_W:0]   rsum;

    always_comb
    begin
        rsum       = {1'b0, r1} + {1'b0, r2};
        rmean_next = rsum[CHAN_W:1];
        dr_next    = (r1 >= r2) ? (r1 - r2) : (r2 - r1);
        dg_next    = (g1 >= g2) ? (g1 - g2) : (g2 - g1);
        db_next    = (b1 >= b2) ? (b1 - b2) : (b2 - b1);
    end

    // Stage 2: squares and the two red-mean weights (512+m, 767-m).
    logic [2*CHAN_W-1:0] dr2_reg, dg2_reg, db2_reg;
    logic [9:0]          wr_reg, wb_reg;
    logic [2*CHAN_W-1:0] dr2_next, dg2_next, db2_next;
    logic [9:0]          wr_next, wb_next;

    always_comb
    begin
        dr2_next = dr_reg * dr_reg;
        dg2_next = dg_reg * dg_reg;
        db2_next = db_reg * db_reg;
        wr_next  = 10'd512 + {2'b00, rmean_reg};
        wb_next  = 10'd767 - {2'b00, rmean_reg};
    end

    // Stage 3: weighted terms; red and blue products floored by 256, green is 4*dg^2.
    logic [17:0] red_term_reg, green_term_reg, blue_term_reg;
    logic [17:0] red_term_next, green_term_next, blue_term_next;
    logic [25:0] red_prod, blue_prod;

    always_comb
    begin
        red_prod        = wr_reg * dr2_reg;
        blue_prod       = wb_reg * db2_reg;
        red_term_next   = red_prod[25:8];
        blue_term_next  = blue_prod[25:8];
        green_term_next = {dg2_reg, 2'b00};
    end

    // Stage 4: total; the largest reachable sum stays inside 20 bits.
    logic [SUM_W-1:0] sum_reg, sum_next;

    always_comb
    begin
        sum_next = {2'b00, red_term_reg} + {2'b00, green_term_reg}
                 + {2'b00, blue_term_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= s_tvalid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s_tvalid)
        begin
            rmean_reg <= rmean_next;
            dr_reg    <= dr_next;
            dg_reg    <= dg_next;
            db_reg    <= db_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            dr2_reg <= dr2_next;
            dg2_reg <= dg2_next;
            db2_reg <= db2_next;
            wr_reg  <= wr_next;
            wb_reg  <= wb_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            red_term_reg   <= red_term_next;
            green_term_reg <= green_term_next;
            blue_term_reg  <= blue_term_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    // Square root of sum*256; the last root stage is the output register.
    logic [SUM_W-1:0]  out_sum;
    logic [DIST_W-1:0] out_root;

    rmcd_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .in_ready  (sq_ready),
        .in_sum    (sum_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sum   (out_sum),
        .out_root  (out_root)
    );

    assign m_tdata = {6'b000000, out_root, out_sum};

    // Root bracket: root^2 <= sum*256 < (root+1)^2.
    logic [29:0] chk_rad, chk_sq, chk_sq1;
    assign chk_rad = {2'b00, out_sum, 8'h00};
    assign chk_sq  = {16'd0, out_root} * {16'd0, out_root};
    assign chk_sq1 = ({16'd0, out_root} + 30'd1) * ({16'd0, out_root} + 30'd1);

    a_root_low: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> chk_sq <= chk_rad)
        else $error("distance root too large for its sum");

    a_root_high: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> chk_sq1 > chk_rad)
        else $error("distance root too small for its sum");

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_sum <= 20'd584970)
        else $error("weighted sum beyond reachable range");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input blocked while output side is free");

endmodule

[sim/tb_redmean_color_distance_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_redmean_color_distance_unit
// Self-checking bench for the redmean color distance pipeline.
// ----------------------------------------------------------------------------
//
//  A table of hand-picked color pairs runs first: identical colors, black
//  against white, single-channel steps and bit patterns. Rows whose answer
//  is obvious carry it; the rest go to the built-in distance predictor.
//  After that, four phases of random pairs run with different amounts of
//  sender idling and receiver back-pressure. Every result is checked in
//  order against the queue of predicted distances.
//
module tb_redmean_color_distance_unit
    import rmcd_pkg::*;
();

    localparam int PAIRS_PER_PHASE = 475;
    localparam int DRAIN_CYCLES    = 40;    // slack to watch for stray results
    localparam int STALL_LIMIT     = 2000;  // cycles without any handshake

    // Color pair laid out as on s_tdata: first_red in the lowest byte.
    typedef struct packed {
        logic [CHAN_W-1:0] second_blue;
        logic [CHAN_W-1:0] second_green;
        logic [CHAN_W-1:0] second_red;
        logic [CHAN_W-1:0] first_blue;
        logic [CHAN_W-1:0] first_green;
        logic [CHAN_W-1:0] first_red;
    } rgb_pair_t;

    typedef struct packed {
        logic [SUM_W-1:0]  weighted_sum;
        logic [DIST_W-1:0] distance_q4;
    } distance_t;

    typedef struct {
        int unsigned fr, fg, fb, sr, sg, sb;
        bit          known;   // answer typed in below
        int unsigned sum;
        int unsigned root_q4;
    } pair_row_t;

    // Hand-picked pairs: extremes, single steps, truncation and bit patterns.
    pair_row_t pair_rows [21] = '{
        '{  0,   0,   0,   0,   0,   0, 1'b1,      0,     0},  // identical black
        '{255, 255, 255, 255, 255, 255, 1'b1,      0,     0},  // identical white
        '{  0,   0,   0, 255, 255, 255, 1'b1, 584970, 12237},  // largest sum
        '{255, 255, 255,   0,   0,   0, 1'b1, 584970, 12237},
        '{  0,   0,   0,   0, 255,   0, 1'b1, 260100,  8160},  // green only
        '{  0, 255,   0,   0,   0,   0, 1'b1, 260100,  8160},
        '{  0,   0,   0,   0,   1,   0, 1'b1,      4,    32},  // one green step
        '{  0, 128,   0,   0, 127,   0, 1'b1,      4,    32},
        '{  0,   0,   0, 255,   0,   0, 1'b0,      0,     0},  // red only
        '{255,   0,   0,   0,   0,   0, 1'b0,      0,     0},
        '{  0,   0,   0,   0,   0, 255, 1'b0,      0,     0},  // blue only
        '{255,   0,   0, 255,   0, 255, 1'b0,      0,     0},  // rmean at top
        '{  1,   0,   0,   0,   0,   0, 1'b0,      0,     0},  // one red step
        '{  0,   0,   1,   0,   0,   0, 1'b0,      0,     0},  // blue weight floors
        '{255,   9,   9, 254,   9,   9, 1'b0,      0,     0},
        '{  0,   0,   3,   0,   0,   0, 1'b0,      0,     0},
        '{170, 170, 170,  85,  85,  85, 1'b0,      0,     0},
        '{ 85,  85,  85, 170, 170, 170, 1'b0,      0,     0},
        '{ 15, 240,  15, 240,  15, 240, 1'b0,      0,     0},
        '{128, 127, 128, 127, 128, 127, 1'b0,      0,     0},
        '{  1,   2,   4,   8,  16,  32, 1'b0,      0,     0}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    distance_t   pending_distances [$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned sink_stall_pct  = 0;

    redmean_color_distance_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Floor of the square root, found by trial squaring from the top bit down.
    function automatic logic [DIST_W-1:0] floor_root(input int unsigned radicand);
        int unsigned root;
        int unsigned trial;
        root = 0;
        for (int b = DIST_W - 1; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        return DIST_W'(root);
    endfunction

    // Weighted redmean sum and its Q4 root for one color pair.
    function automatic distance_t redmean_distance(input rgb_pair_t pair);
        distance_t   res;
        int unsigned rmean;
        int unsigned dr;
        int unsigned dg;
        int unsigned db;
        int unsigned total;
        rmean = (int'(pair.first_red) + int'(pair.second_red)) >> 1;
        dr = (pair.first_red > pair.second_red) ? pair.first_red - pair.second_red
                                                : pair.second_red - pair.first_red;
        dg = (pair.first_green > pair.second_green) ? pair.first_green - pair.second_green
                                                    : pair.second_green - pair.first_green;
        db = (pair.first_blue > pair.second_blue) ? pair.first_blue - pair.second_blue
                                                  : pair.second_blue - pair.first_blue;
        total = (((512 + rmean) * dr * dr) >> 8) + 4 * dg * dg
              + (((767 - rmean) * db * db) >> 8);
        res.weighted_sum = SUM_W'(total);
        res.distance_q4  = floor_root(total << 8);
        return res;
    endfunction

    // Move a channel by a small amount, clamped to the channel range.
    function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] base);
        int v;
        v = int'(base) + int'($urandom_range(0, 16)) - 8;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return CHAN_W'(v);
    endfunction

    // Mostly uniform pairs, plus near colors, extremes, identical colors
    // and pairs that differ in one channel only.
    function automatic rgb_pair_t random_pair();
        rgb_pair_t   pair;
        int unsigned kind;
        int unsigned chan;
        pair = {$urandom(), 16'($urandom())};
        kind = $urandom_range(0, 9);
        chan = $urandom_range(0, 2);
        case (kind)
            5, 6:
            begin
                pair.second_red   = nudge(pair.first_red);
                pair.second_green = nudge(pair.first_green);
                pair.second_blue  = nudge(pair.first_blue);
            end
            7:
            begin
                pair = {6{$urandom_range(0, 1) ? 8'hFF : 8'h00}};
                pair.first_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                pair.second_blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                pair.second_red  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            8, 9:
            begin
                pair.second_red   = pair.first_red;
                pair.second_green = pair.first_green;
                pair.second_blue  = pair.first_blue;
                if (kind == 9)
                begin
                    if (chan == 0)
                        pair.second_red = CHAN_W'($urandom());
                    else if (chan == 1)
                        pair.second_green = CHAN_W'($urandom());
                    else
                        pair.second_blue = CHAN_W'($urandom());
                end
            end
            default:
            begin
            end
        endcase
        return pair;
    endfunction

    // Offer one request, hold it until accepted, then queue its expected
    // distance. A typed answer overrides the predictor.
    task automatic send_pair(input rgb_pair_t pair, input bit known,
                             input distance_t known_result);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pair;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_distances.push_back(known ? known_result : redmean_distance(pair));
    endtask

    // Receiver back-pressure.
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // Check each result against the oldest expected distance.
    always @(posedge clk)
    begin
        distance_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_distances.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_distances.pop_front();
                if (m_tdata[SUM_W-1:0] !== want.weighted_sum)
                begin
                    $display("%0t: weighted_sum mismatch: expected %0d, got %0d",
                             $time, want.weighted_sum, m_tdata[SUM_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[SUM_W+DIST_W-1:SUM_W] !== want.distance_q4)
                begin
                    $display("%0t: distance_q4 mismatch: expected %0d, got %0d",
                             $time, want.distance_q4, m_tdata[SUM_W+DIST_W-1:SUM_W]);
                    mismatch_count++;
                end
            end
        end
    end

    // Drop the run if neither side moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("redmean_color_distance_unit regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rgb_pair_t pair;
        distance_t known_result;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, no idling on either side.
        foreach (pair_rows[i])
        begin
            pair.first_red    = CHAN_W'(pair_rows[i].fr);
            pair.first_green  = CHAN_W'(pair_rows[i].fg);
            pair.first_blue   = CHAN_W'(pair_rows[i].fb);
            pair.second_red   = CHAN_W'(pair_rows[i].sr);
            pair.second_green = CHAN_W'(pair_rows[i].sg);
            pair.second_blue  = CHAN_W'(pair_rows[i].sb);
            known_result.weighted_sum = SUM_W'(pair_rows[i].sum);
            known_result.distance_q4  = DIST_W'(pair_rows[i].root_q4);
            send_pair(pair, pair_rows[i].known, known_result);
        end

        // Random phases: free flow, sender gaps, receiver stalls, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 56; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 56; end
                default: begin sender_idle_pct = 37; sink_stall_pct = 37; end
            endcase
            repeat (PAIRS_PER_PHASE)
                send_pair(random_pair(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // Drain, then watch a little longer for stray results.
        while (pending_distances.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("redmean_color_distance_unit regression: pass");
        else
            $display("redmean_color_distance_unit regression: fail");
        $finish;
    end

endmodule
